// ===== hdl/tta_pkg.sv =====
package tta_pkg;

    localparam int MAX_RANK   = 6;
    localparam int INDEX_BITS = 24;

    localparam int RANK_W     = 3;
    localparam int AXIS_W     = 3;
    localparam int ORDER_W    = AXIS_W * MAX_RANK;
    localparam int SIZE_W     = 13;
    localparam int CNT_W      = SIZE_W;
    localparam int LVL_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int IDX_W      = INDEX_BITS;
    localparam int TOT_W      = INDEX_BITS + 1;
    localparam int MUL_W      = TOT_W + SIZE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ORDER_W;

    localparam logic [SIZE_W-1:0]  SIZE_LIMIT = SIZE_W'(4096);
    localparam logic [MUL_W-1:0]   ELEM_LIMIT = MUL_W'(1) << INDEX_BITS;

    // register map of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RANK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = CFG_IDX_W'(2);

    localparam logic [RANK_W-1:0]  RANK_RESET  = RANK_W'(1);
    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(181896);
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_EVAL,
        ST_EMIT,
        ST_ADV
    } t_state;

    typedef struct packed {
        logic             rank_ok;
        logic             base_ok;
        logic [LVL_W-1:0] last_axis;
    } t_cfg_stat;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LVL_W-1:0]  lvl;
    } t_axis_info;

    typedef struct packed {
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dest;
        logic             last;
        logic             err;
    } t_result;

endpackage

// ===== hdl/tta_cfg.sv =====
module tta_cfg import tta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [LVL_W-1:0]      i_axis_sel,
    output t_cfg_stat             o_stat,
    output t_axis_info            o_axis
);

    logic [RANK_W-1:0]  r_rank;
    logic [ORDER_W-1:0] r_order;
    logic [SIZE_W-1:0]  r_size [MAX_RANK];

    logic perm_bad;
    logic size_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= RANK_RESET;
            r_order <= ORDER_RESET;
            for (int i = 0; i < MAX_RANK; i++) begin
                r_size[i] <= SIZE_RESET;
            end
        end else if (i_cfg_wen) begin
            if (i_cfg_index == REG_RANK) begin
                r_rank <= i_cfg_data[RANK_W-1:0];
            end
            if (i_cfg_index == REG_ORDER) begin
                r_order <= i_cfg_data[ORDER_W-1:0];
            end
            for (int i = 0; i < MAX_RANK; i++) begin
                if (i_cfg_index == CFG_IDX_W'(REG_SIZE0 + i)) begin
                    r_size[i] <= i_cfg_data[SIZE_W-1:0];
                end
            end
        end
    end

    // config check: used fields name used axes and differ; used sizes 1..4096
    always_comb begin
        perm_bad = 1'b0;
        size_bad = 1'b0;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (RANK_W'(i) < r_rank) begin
                if (RANK_W'(r_order[AXIS_W*i +: AXIS_W]) >= r_rank) begin
                    perm_bad = 1'b1;
                end
                if (r_size[i] == '0 || r_size[i] > SIZE_LIMIT) begin
                    size_bad = 1'b1;
                end
                for (int m = i + 1; m < MAX_RANK; m++) begin
                    if (RANK_W'(m) < r_rank &&
                        r_order[AXIS_W*i +: AXIS_W] == r_order[AXIS_W*m +: AXIS_W]) begin
                        perm_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_stat.rank_ok   = (r_rank != '0) && (r_rank <= RANK_W'(MAX_RANK));
        o_stat.base_ok   = o_stat.rank_ok && !perm_bad && !size_bad;
        o_stat.last_axis = LVL_W'(r_rank - RANK_W'(1));
    end

    // source axis -> counter level that walks it (inverse of the axis order)
    always_comb begin
        o_axis.size = r_size[i_axis_sel];
        o_axis.lvl  = '0;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (RANK_W'(i) < r_rank &&
                LVL_W'(r_order[AXIS_W*i +: AXIS_W]) == i_axis_sel) begin
                o_axis.lvl = LVL_W'(r_rank - RANK_W'(1) - RANK_W'(i));
            end
        end
    end

endmodule

// ===== hdl/tta_walk.sv =====
module tta_walk import tta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_restart,
    input  logic             i_slot_free,
    input  t_cfg_stat        i_stat,
    input  t_axis_info       i_axis,
    output logic [LVL_W-1:0] o_axis_sel,
    output logic             o_busy,
    output logic             o_res_load,
    output t_result          o_res
);

    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(MAX_RANK - 1);

    t_state             r_state, n_state;
    logic               r_restart, n_restart;
    logic [LVL_W-1:0]   r_k, n_k;
    logic [LVL_W-1:0]   r_j, n_j;
    logic [TOT_W-1:0]   r_prod, n_prod;
    logic               r_ovf, n_ovf;
    logic               r_err, n_err;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [IDX_W-1:0]   r_src, n_src;
    logic [IDX_W-1:0]   r_dest, n_dest;
    logic [CNT_W-1:0]   r_cnt [MAX_RANK];
    logic [CNT_W-1:0]   n_cnt [MAX_RANK];
    logic [CNT_W-1:0]   r_ext [MAX_RANK];
    logic [CNT_W-1:0]   n_ext [MAX_RANK];
    logic [IDX_W-1:0]   r_stride [MAX_RANK];
    logic [IDX_W-1:0]   n_stride [MAX_RANK];
    logic [IDX_W-1:0]   r_wrap [MAX_RANK];
    logic [IDX_W-1:0]   n_wrap [MAX_RANK];

    logic [MUL_W-1:0]   w_mul;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [IDX_W-1:0]   w_step;
    logic [TOT_W-1:0]   w_dest_inc;
    logic               w_last;
    logic               w_carry;
    logic               w_ok;

    // shared multiplier for the suffix products of the dimension sizes
    assign w_mul      = MUL_W'(r_prod) * MUL_W'(i_axis.size);
    assign w_cnt_inc  = r_cnt[r_j] + CNT_W'(1);
    assign w_step     = r_src + r_stride[r_j];
    assign w_dest_inc = TOT_W'(r_dest) + TOT_W'(1);
    assign w_last     = w_dest_inc >= r_total;
    assign w_carry    = (r_j != TOP_LVL) && (w_cnt_inc >= r_ext[r_j]);
    assign w_ok       = i_stat.base_ok && !r_ovf;

    assign o_axis_sel = r_k;
    assign o_busy     = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        n_k       = r_k;
        n_j       = r_j;
        n_prod    = r_prod;
        n_ovf     = r_ovf;
        n_err     = r_err;
        n_total   = r_total;
        n_src     = r_src;
        n_dest    = r_dest;
        n_cnt     = r_cnt;
        n_ext     = r_ext;
        n_stride  = r_stride;
        n_wrap    = r_wrap;
        o_res_load = 1'b0;
        o_res.src  = '0;
        o_res.dest = '0;
        o_res.last = 1'b0;
        o_res.err  = r_err;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_restart = i_restart;
                    n_prod    = TOT_W'(1);
                    n_ovf     = 1'b0;
                    n_k       = i_stat.last_axis;
                    if (i_restart) begin
                        for (int l = 0; l < MAX_RANK; l++) begin
                            n_cnt[l]    = '0;
                            n_ext[l]    = CNT_W'(1);
                            n_stride[l] = '0;
                            n_wrap[l]   = '0;
                        end
                    end
                    n_state = i_stat.rank_ok ? ST_PROD : ST_EVAL;
                end
            end
            ST_PROD: begin
                // before the multiply r_prod is the stride of axis k, after it the wrap
                n_prod = w_mul[TOT_W-1:0];
                if (w_mul > ELEM_LIMIT) begin
                    n_ovf = 1'b1;
                end
                if (r_restart) begin
                    for (int l = 0; l < MAX_RANK; l++) begin
                        if (LVL_W'(l) == i_axis.lvl) begin
                            n_ext[l]    = i_axis.size;
                            n_stride[l] = r_prod[IDX_W-1:0];
                            n_wrap[l]   = w_mul[IDX_W-1:0];
                        end
                    end
                end
                if (r_k == '0) begin
                    n_state = ST_EVAL;
                end else begin
                    n_k = r_k - LVL_W'(1);
                end
            end
            ST_EVAL: begin
                n_err = !w_ok;
                if (r_restart) begin
                    n_total = w_ok ? r_prod : '0;
                    n_src   = '0;
                    n_dest  = '0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    o_res_load = 1'b1;
                    if (r_total == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_res.src  = r_src;
                        o_res.dest = r_dest;
                        o_res.last = w_last;
                        if (w_last) begin
                            // end of the walk: start over at element zero
                            for (int l = 0; l < MAX_RANK; l++) begin
                                n_cnt[l] = '0;
                            end
                            n_src   = '0;
                            n_dest  = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_dest  = w_dest_inc[IDX_W-1:0];
                            n_j     = '0;
                            n_state = ST_ADV;
                        end
                    end
                end
            end
            ST_ADV: begin
                // one counter level per cycle, carry moves up
                if (w_carry) begin
                    n_src      = w_step - r_wrap[r_j];
                    n_cnt[r_j] = '0;
                    n_j        = r_j + LVL_W'(1);
                end else begin
                    n_src      = w_step;
                    n_cnt[r_j] = w_cnt_inc;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_restart <= 1'b0;
            r_k       <= '0;
            r_j       <= '0;
            r_prod    <= '0;
            r_ovf     <= 1'b0;
            r_err     <= 1'b0;
            r_total   <= '0;
            r_src     <= '0;
            r_dest    <= '0;
            for (int l = 0; l < MAX_RANK; l++) begin
                r_cnt[l]    <= '0;
                r_ext[l]    <= '0;
                r_stride[l] <= '0;
                r_wrap[l]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
            r_k       <= n_k;
            r_j       <= n_j;
            r_prod    <= n_prod;
            r_ovf     <= n_ovf;
            r_err     <= n_err;
            r_total   <= n_total;
            r_src     <= n_src;
            r_dest    <= n_dest;
            r_cnt     <= n_cnt;
            r_ext     <= n_ext;
            r_stride  <= n_stride;
            r_wrap    <= n_wrap;
        end
    end

    a_adv_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADV |-> r_j <= TOP_LVL)
        else $error("carry ran past the top counter level");

    a_dest_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_total != '0) |-> TOT_W'(r_dest) < r_total)
        else $error("output index outside the loaded walk");

    a_level0_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_total != '0) |-> r_cnt[0] < r_ext[0])
        else $error("innermost counter not below its extent");

    a_prod_needs_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PROD |-> i_stat.rank_ok)
        else $error("size pass started with an unusable rank");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> r_state == ST_PROD || r_state == ST_EVAL)
        else $error("accepted word did not start the size pass");

endmodule

// ===== hdl/tensor_transpose_address_gen_top.sv =====
// channel   direction  handshake                  payload
// in        in         i_in_valid / o_in_stall    i_restart
// out       out        o_out_valid / i_out_stall  o_source_index, o_dest_index,
//                                                 o_last, o_config_error
// cfg       in         i_cfg_wen                  i_cfg_index, i_cfg_data
//
// a word passes through accept, a shared-multiplier pass over the dimension sizes,
// evaluate, emit and advance; the advance repeats for each counter level that
// carries. the last element or a word with no walk loaded skips the advance,
// and a rank outside 1..6 skips the multiplier pass.
// o_in_stall is high while a word is in work; a finished word waits in the
// output register, and a stalled output holds the block before its next result.
// reset is synchronous, active low, and leaves no walk loaded.
module tensor_transpose_address_gen_top import tta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_source_index,
    output logic [IDX_W-1:0]      o_dest_index,
    output logic                  o_last,
    output logic                  o_config_error,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_stat        stat;
    t_axis_info       axis;
    t_result          res;
    logic [LVL_W-1:0] axis_sel;
    logic             busy;
    logic             res_load;
    logic             slot_free;

    logic             r_out_valid;
    t_result          r_out;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy;

    tta_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_axis_sel  (axis_sel),
        .o_stat      (stat),
        .o_axis      (axis)
    );

    tta_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_restart   (i_restart),
        .i_slot_free (slot_free),
        .i_stat      (stat),
        .i_axis      (axis),
        .o_axis_sel  (axis_sel),
        .o_busy      (busy),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_source_index = r_out.src;
    assign o_dest_index   = r_out.dest;
    assign o_last         = r_out.last;
    assign o_config_error = r_out.err;

endmodule
